@@ rtl/tapqm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapqm_pkg
// Shared types, constants and command bundle of the three-axis pid with mixer
// ----------------------------------------------------------------------------
package tapqm_pkg;

  // default motor duty ceiling
  localparam int unsigned DUTY_MAX_DEF = 1023;

  // field widths
  localparam int unsigned AngW  = 16;
  localparam int unsigned ErrW  = 17;
  localparam int unsigned DtW   = 16;
  localparam int unsigned ThrW  = 10;
  localparam int unsigned DutyW = 10;
  localparam int unsigned LimW  = 15;
  localparam int unsigned GainW = 16;
  localparam int unsigned DW    = 24;
  localparam int unsigned QuoW  = 33;
  localparam int unsigned MulAW = 25;
  localparam int unsigned ProdW = 42;
  localparam int unsigned AccW  = 44;
  localparam int unsigned NumAx = 3;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // low throttle threshold
  localparam logic [ThrW-1:0] LowThrottle = 10'd50;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegKpRoll      = 3'd0;
  localparam logic [CfgAddrW-1:0] RegKpPitch     = 3'd1;
  localparam logic [CfgAddrW-1:0] RegKpYaw       = 3'd2;
  localparam logic [CfgAddrW-1:0] RegKiRollPitch = 3'd3;
  localparam logic [CfgAddrW-1:0] RegKiYaw       = 3'd4;
  localparam logic [CfgAddrW-1:0] RegKdRollPitch = 3'd5;
  localparam logic [CfgAddrW-1:0] RegKdYaw       = 3'd6;
  localparam logic [CfgAddrW-1:0] RegOutLimit    = 3'd7;

  // axis codes
  localparam logic [1:0] AxRoll  = 2'd0;
  localparam logic [1:0] AxPitch = 2'd1;
  localparam logic [1:0] AxYaw   = 2'd2;

  // schedule of the run phase (step counter values)
  localparam int unsigned StepW     = 6;
  localparam int unsigned KEdt      = 0;
  localparam int unsigned KKp       = 3;
  localparam int unsigned KKi       = 6;
  localparam int unsigned KDivLast  = QuoW - 1;
  localparam int unsigned KDsat     = QuoW;
  localparam int unsigned KKd       = QuoW + 1;
  localparam int unsigned KRunLast  = KKd + NumAx;

  // multiplier operation tags
  typedef enum logic [1:0] {
    OP_EDT = 2'd0,
    OP_KP  = 2'd1,
    OP_KI  = 2'd2,
    OP_KD  = 2'd3
  } mul_op_e;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       prep;
    logic       div_step;
    logic       dsat;
    logic       mul_valid;
    mul_op_e    mul_op;
    logic [1:0] mul_axis;
    logic       fin;
    logic       out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/tapqm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapqm_ctrl
// Sequencer: steps one tick through prep, divide and multiply schedule, output
// ----------------------------------------------------------------------------
module tapqm_ctrl import tapqm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             ovalid_q, ovalid_d;
  logic             out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

  // next state and command decode
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.div_step = (step_q <= StepW'(KDivLast));
        cmd_o.dsat     = (step_q == StepW'(KDsat));
        if (step_q < StepW'(KKp)) begin
          cmd_o.mul_valid = 1'b1;
          cmd_o.mul_op    = OP_EDT;
          cmd_o.mul_axis  = 2'(step_q - StepW'(KEdt));
        end else if (step_q < StepW'(KKi)) begin
          cmd_o.mul_valid = 1'b1;
          cmd_o.mul_op    = OP_KP;
          cmd_o.mul_axis  = 2'(step_q - StepW'(KKp));
        end else if (step_q < StepW'(KKi + NumAx)) begin
          cmd_o.mul_valid = 1'b1;
          cmd_o.mul_op    = OP_KI;
          cmd_o.mul_axis  = 2'(step_q - StepW'(KKi));
        end else if (step_q >= StepW'(KKd) && step_q < StepW'(KKd + NumAx)) begin
          cmd_o.mul_valid = 1'b1;
          cmd_o.mul_op    = OP_KD;
          cmd_o.mul_axis  = 2'(step_q - StepW'(KKd));
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(KRunLast)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tapqm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapqm_dp
// Datapath: gain registers, axis state, three divider lanes, shared multiplier
// ----------------------------------------------------------------------------
module tapqm_dp import tapqm_pkg::*; #(
  parameter int unsigned DUTY_MAX = DUTY_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  cmd_t                     cmd_i,
  output logic [OutDataW-1:0]      out_data_o
);

  localparam logic signed [17:0] DutyLim = 18'(DUTY_MAX);

  // configuration
  logic [GainW-1:0] kp_q [NumAx];
  logic [GainW-1:0] ki_rp_q, ki_y_q, kd_rp_q, kd_y_q;
  logic [LimW-1:0]  lim_q;

  // tick operands and per-axis state
  logic signed [ErrW-1:0]  e_q     [NumAx];
  logic signed [ErrW-1:0]  prev_q  [NumAx];
  logic signed [AngW-1:0]  integ_q [NumAx];
  logic signed [AccW-1:0]  acc_q   [NumAx];
  logic [QuoW-1:0]         quo_q   [NumAx];
  logic [DtW-1:0]          rem_q   [NumAx];
  logic                    dneg_q  [NumAx];
  logic                    dzero_q [NumAx];
  logic signed [DW-1:0]    d_q     [NumAx];
  logic signed [AngW-1:0]  drv_q   [NumAx];
  logic [DtW-1:0]          dt_q;
  logic [ThrW-1:0]         thr_q;

  // multiplier pipeline
  logic signed [ProdW-1:0] prod_q;
  logic                    pv_q;
  mul_op_e                 pop_q;
  logic [1:0]              pax_q;
  logic signed [MulAW-1:0] mul_a;
  logic [GainW-1:0]        mul_b;
  logic signed [ProdW-1:0] prod_d;

  logic signed [LimW:0]    lim_s;
  logic [OutDataW-1:0]     out_q;

  assign lim_s      = $signed({1'b0, lim_q});
  assign out_data_o = out_q;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q[0] <= 16'd307;
      kp_q[1] <= 16'd307;
      kp_q[2] <= 16'd512;
      ki_rp_q <= '0;
      ki_y_q  <= '0;
      kd_rp_q <= '0;
      kd_y_q  <= '0;
      lim_q   <= 15'd6400;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegKpRoll:      kp_q[0] <= cfg_wdata_i;
        RegKpPitch:     kp_q[1] <= cfg_wdata_i;
        RegKpYaw:       kp_q[2] <= cfg_wdata_i;
        RegKiRollPitch: ki_rp_q <= cfg_wdata_i;
        RegKiYaw:       ki_y_q  <= cfg_wdata_i;
        RegKdRollPitch: kd_rp_q <= cfg_wdata_i;
        RegKdYaw:       kd_y_q  <= cfg_wdata_i;
        RegOutLimit:    lim_q   <= cfg_wdata_i[LimW-1:0];
        default:        ;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    for (int i = 0; i < NumAx; i++) begin
      if (cmd_i.mul_axis == 2'(i)) begin
        case (cmd_i.mul_op)
          OP_EDT: begin
            mul_a = MulAW'(e_q[i]);
            mul_b = dt_q;
          end
          OP_KP: begin
            mul_a = MulAW'(e_q[i]);
            mul_b = kp_q[i];
          end
          OP_KI: begin
            mul_a = MulAW'(integ_q[i]);
            mul_b = (i == NumAx - 1) ? ki_y_q : ki_rp_q;
          end
          OP_KD: begin
            mul_a = MulAW'(d_q[i]);
            mul_b = (i == NumAx - 1) ? kd_y_q : kd_rp_q;
          end
          default: ;
        endcase
      end
    end
  end

  assign prod_d = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pop_q  <= cmd_i.mul_op;
    pax_q  <= cmd_i.mul_axis;
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < NumAx; i++) begin
        e_q[i] <= ErrW'($signed(in_data_i[i*AngW +: AngW]))
                - ErrW'($signed(in_data_i[(i+NumAx)*AngW +: AngW]));
      end
      dt_q  <= in_data_i[6*AngW +: DtW];
      thr_q <= in_data_i[6*AngW + DtW +: ThrW];
    end
  end

  // per-axis lanes: divider, derivative saturation, accumulate, drive clamp
  for (genvar g = 0; g < NumAx; g++) begin : g_lane
    logic signed [ErrW:0]   diff;
    logic [ErrW-1:0]        dmag;
    logic [DtW:0]           part;
    logic signed [25:0]     inc;
    logic signed [26:0]     isum;
    logic signed [35:0]     shv;

    assign diff = ErrW'(0) + ((ErrW+1)'(e_q[g]) - (ErrW+1)'(prev_q[g]));
    assign dmag = diff[ErrW] ? ErrW'(-diff) : ErrW'(diff);
    assign part = {rem_q[g], quo_q[g][QuoW-1]};
    assign inc  = prod_q[ProdW-1:16];
    assign isum = 27'(integ_q[g]) + 27'(inc);
    assign shv  = acc_q[g][AccW-1:8];

    // state that survives ticks
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[g]  <= '0;
        integ_q[g] <= '0;
      end else begin
        if (cmd_i.prep) begin
          prev_q[g] <= e_q[g];
        end
        if (pv_q && pop_q == OP_EDT && pax_q == 2'(g)) begin
          if (isum > 27'(lim_s)) begin
            integ_q[g] <= AngW'(lim_s);
          end else if (isum < -27'(lim_s)) begin
            integ_q[g] <= AngW'(-lim_s);
          end else begin
            integ_q[g] <= AngW'(isum);
          end
        end
      end
    end

    // restoring divider of |diff| * 2^16 by dt, one bit a cycle
    always_ff @(posedge clk_i) begin
      if (cmd_i.prep) begin
        quo_q[g]   <= {dmag, 16'd0};
        rem_q[g]   <= '0;
        dneg_q[g]  <= diff[ErrW];
        dzero_q[g] <= (diff == '0);
      end else if (cmd_i.div_step) begin
        if (part >= {1'b0, dt_q}) begin
          rem_q[g] <= DtW'(part - {1'b0, dt_q});
          quo_q[g] <= {quo_q[g][QuoW-2:0], 1'b1};
        end else begin
          rem_q[g] <= part[DtW-1:0];
          quo_q[g] <= {quo_q[g][QuoW-2:0], 1'b0};
        end
      end
    end

    // derivative saturation to 24 bits
    always_ff @(posedge clk_i) begin
      if (cmd_i.dsat) begin
        if (dzero_q[g]) begin
          d_q[g] <= '0;
        end else if (!dneg_q[g]) begin
          d_q[g] <= (quo_q[g] > QuoW'(24'h7FFFFF)) ? 24'sh7FFFFF
                                                  : $signed(quo_q[g][DW-1:0]);
        end else begin
          d_q[g] <= (quo_q[g] > QuoW'(24'h800000)) ? 24'sh800000
                                                  : -$signed(quo_q[g][DW-1:0]);
        end
      end
    end

    // accumulate gain products
    always_ff @(posedge clk_i) begin
      if (pv_q && pax_q == 2'(g)) begin
        case (pop_q)
          OP_KP:   acc_q[g] <= AccW'(prod_q);
          OP_KI,
          OP_KD:   acc_q[g] <= acc_q[g] + AccW'(prod_q);
          default: ;
        endcase
      end
    end

    // drive clamp
    always_ff @(posedge clk_i) begin
      if (cmd_i.fin) begin
        if (shv > 36'(lim_s)) begin
          drv_q[g] <= AngW'(lim_s);
        end else if (shv < -36'(lim_s)) begin
          drv_q[g] <= AngW'(-lim_s);
        end else begin
          drv_q[g] <= AngW'(shv);
        end
      end
    end
  end

  // x-quad mixer
  logic signed [11:0] unit_v [NumAx];
  logic signed [14:0] mix_v  [4];
  logic [DutyW-1:0]   duty_v [4];
  logic signed [14:0] thr_s;

  assign thr_s = $signed({5'd0, thr_q});

  always_comb begin
    for (int i = 0; i < NumAx; i++) begin
      unit_v[i] = 12'((drv_q[i] + (drv_q[i][AngW-1] ? 16'sd15 : 16'sd0)) >>> 4);
    end
    mix_v[0] = thr_s + 15'(unit_v[1]) + 15'(unit_v[0]) - 15'(unit_v[2]);
    mix_v[1] = thr_s + 15'(unit_v[1]) - 15'(unit_v[0]) + 15'(unit_v[2]);
    mix_v[2] = thr_s - 15'(unit_v[1]) - 15'(unit_v[0]) - 15'(unit_v[2]);
    mix_v[3] = thr_s - 15'(unit_v[1]) + 15'(unit_v[0]) + 15'(unit_v[2]);
    for (int m = 0; m < 4; m++) begin
      if (thr_q < LowThrottle || mix_v[m] < 0) begin
        duty_v[m] = '0;
      end else if (18'(mix_v[m]) > DutyLim) begin
        duty_v[m] = DutyLim[DutyW-1:0];
      end else begin
        duty_v[m] = mix_v[m][DutyW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {duty_v[3], duty_v[2], duty_v[1], duty_v[0],
                drv_q[2], drv_q[1], drv_q[0]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/three_axis_pid_with_quad_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an input transaction is followed by prep, a 38-step run phase set
//   by the 33-bit serial divider and the shared multiplier, fin, then output.
// Input: ticks do not overlap; the next tick is taken while a result still
//   waits in the output register.
// Reset: asynchronous active low; gains return to defaults, integrals and
//   previous errors clear, no result pending.
// ----------------------------------------------------------------------------
// three_axis_pid_with_quad_mixer
// Roll, pitch and yaw pid loops with an x-quad motor mixer on stream ports
// ----------------------------------------------------------------------------
module three_axis_pid_with_quad_mixer import tapqm_pkg::*; #(
  parameter int unsigned DUTY_MAX = DUTY_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // setpoint_roll, setpoint_pitch, setpoint_yaw, measured_roll,
  // measured_pitch, measured_yaw, dt_seconds, throttle, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // roll_drive, pitch_drive, yaw_drive, motor_1, motor_2, motor_3, motor_4
  output logic [OutDataW-1:0]      m_axis_tdata
);

  cmd_t cmd;

  tapqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  tapqm_dp #(
    .DUTY_MAX (DUTY_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .out_data_o  (m_axis_tdata)
  );

  // a tick in progress blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a tick is in progress");

  // a result never appears the cycle after a tick starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised too early after input");

  // the multiplier is never commanded together with capture, fin or output load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_valid |-> !cmd.capture && !cmd.out_load && !cmd.fin)
    else $error("multiply issued outside run phase");

endmodule

`default_nettype wire
